// ===== design/serl_pkg.sv =====
// serl_pkg: shared types and constants for the sequenced event ring log
// holds transaction structs, request codes and controller/datapath command types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package serl_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;

    // ring address, held count and wrap-sum widths
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW = $clog2(DEPTH + 1);
    localparam int SW = HW + 1;
    localparam int WW = (HW > 8) ? HW : 8;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_SINCE  = 2'd1;
    localparam logic [1:0] REQ_TAIL   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] event_payload;
        logic [63:0] after_seq;
        logic [7:0]  tail_count;
    } req_item_t;

    typedef struct packed {
        logic        has_record;
        logic [63:0] record_seq;
        logic [31:0] record_payload;
        logic        last;
        logic        gap_before;
        logic [6:0]  held_count;
        logic [63:0] next_seq;
        logic [31:0] dropped_count;
    } rsp_item_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_APPEND,
        EMIT_CLEAR,
        EMIT_EMPTY,
        EMIT_PEND,
        EMIT_READ
    } emit_sel_t;

    typedef struct packed {
        logic      append;
        logic      clear;
        logic      start;
        logic      do_read;
        logic      take_pend;
        logic      since;
        emit_sel_t emit;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic walk_done;
        logic cnt_zero;
        logic rd_match;
        logic pend_valid;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/serl_ctrl.sv =====
// serl_ctrl: request sequencer for the ring log
// decodes accepted requests and steps the datapath through ring walks
// depends on serl_pkg
`timescale 1ns / 1ps
`default_nettype none

module serl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  serl_pkg::dp_status_t status,
    output serl_pkg::dp_cmd_t   cmd
);
    import serl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   since_reg, since_next;

    always_comb
    begin
        state_next    = state_reg;
        since_next    = since_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.emit      = EMIT_NONE;
        cmd.since     = since_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = status.out_free;
                if (req_valid && status.out_free)
                begin
                    case (req_type)
                        REQ_APPEND:
                        begin
                            cmd.append = 1'b1;
                            cmd.emit   = EMIT_APPEND;
                            cmd.last   = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            cmd.emit  = EMIT_CLEAR;
                            cmd.last  = 1'b1;
                        end
                        default:
                        begin
                            cmd.start  = 1'b1;
                            since_next = (req_type == REQ_SINCE);
                            state_next = S_WALK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (status.walk_done)
                    state_next = S_FINISH;
                else
                begin
                    cmd.do_read = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (since_reg)
                begin
                    // one matching record is held back so the final one can carry last
                    if (!status.rd_match)
                        state_next = S_WALK;
                    else if (!status.pend_valid)
                    begin
                        cmd.take_pend = 1'b1;
                        state_next    = S_WALK;
                    end
                    else if (status.out_free)
                    begin
                        cmd.emit      = EMIT_PEND;
                        cmd.take_pend = 1'b1;
                        state_next    = S_WALK;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.emit   = EMIT_READ;
                    cmd.last   = status.walk_done;
                    state_next = S_WALK;
                end
            end
            S_FINISH:
            begin
                if (since_reg)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = status.pend_valid ? EMIT_PEND : EMIT_EMPTY;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!status.cnt_zero)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit   = EMIT_EMPTY;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            since_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            since_reg <= since_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/serl_dpath.sv =====
// serl_dpath: ring storage, counters, walk pointer and output register
// executes commands from serl_ctrl and reports walk status back
// depends on serl_pkg
`timescale 1ns / 1ps
`default_nettype none

module serl_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  serl_pkg::req_item_t  req,
    input  serl_pkg::dp_cmd_t    cmd,
    output serl_pkg::dp_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output serl_pkg::rsp_item_t  rsp
);
    import serl_pkg::*;

    logic [PAYLOAD_BITS-1:0] ring_payload [DEPTH];
    logic [63:0]             ring_seq     [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [HW-1:0] held_reg, held_next;
    logic [63:0]   seq_reg, seq_next;
    logic [31:0]   drops_reg, drops_next;

    logic [HW-1:0] idx_reg, idx_next;
    logic [HW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          gap_reg, gap_next;
    logic          rd_first_reg, rd_first_next;
    logic          out_valid_reg, out_valid_next;

    logic [63:0]             cursor_reg;
    logic [63:0]             rd_seq_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;
    logic [63:0]             pend_seq_reg;
    logic [PAYLOAD_BITS-1:0] pend_pay_reg;
    rsp_item_t               rsp_reg, rsp_next;

    logic [PAYLOAD_BITS-1:0] pay_in;
    logic [HW-1:0]           walk_n;
    logic [SW-1:0]           first_sum;
    logic [AW-1:0]           first_slot;
    logic                    gap_calc;

    assign pay_in = PAYLOAD_BITS'(req.event_payload);

    // walk length and start slot for a new since or tail request
    always_comb
    begin
        if (req.req_type == REQ_TAIL && WW'(req.tail_count) < WW'(held_reg))
            walk_n = HW'(req.tail_count);
        else
            walk_n = held_reg;
        first_sum = SW'(head_reg) + SW'(DEPTH) - SW'(walk_n);
        if (first_sum >= SW'(DEPTH))
            first_slot = AW'(first_sum - SW'(DEPTH));
        else
            first_slot = AW'(first_sum);
    end

    // oldest beyond cursor + 1, without wrap
    assign gap_calc = (rd_seq_reg > cursor_reg) && ((rd_seq_reg - cursor_reg) != 64'd1);

    always_comb
    begin
        head_next  = head_reg;
        held_next  = held_reg;
        seq_next   = seq_reg;
        drops_next = drops_reg;
        if (cmd.append)
        begin
            seq_next = seq_reg + 64'd1;
            if (held_reg == HW'(DEPTH))
            begin
                if (drops_reg != '1)
                    drops_next = drops_reg + 32'd1;
            end
            else
                held_next = held_reg + HW'(1);
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        if (cmd.clear)
        begin
            head_next  = '0;
            held_next  = '0;
            drops_next = '0;
        end
    end

    always_comb
    begin
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_valid_next = pend_valid_reg;
        gap_next        = gap_reg;
        rd_first_next   = cmd.do_read && (idx_reg == '0);
        if (cmd.start)
        begin
            idx_next        = '0;
            cnt_next        = walk_n;
            rd_ptr_next     = first_slot;
            pend_valid_next = 1'b0;
            gap_next        = (held_reg == '0) && (drops_reg != '0);
        end
        else if (rd_first_reg)
            gap_next = gap_calc;
        if (cmd.do_read)
        begin
            idx_next    = idx_reg + HW'(1);
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (cmd.take_pend)
            pend_valid_next = 1'b1;

        if (cmd.emit != EMIT_NONE)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // result assembly; status fields show the state after the request
    always_comb
    begin
        rsp_next                = '0;
        rsp_next.last           = cmd.last;
        rsp_next.held_count     = 7'(held_next);
        rsp_next.next_seq       = seq_next;
        rsp_next.dropped_count  = drops_next;
        case (cmd.emit)
            EMIT_APPEND:
            begin
                rsp_next.has_record     = 1'b1;
                rsp_next.record_seq     = seq_reg;
                rsp_next.record_payload = 32'(pay_in);
            end
            EMIT_EMPTY:
            begin
                rsp_next.gap_before = cmd.since & gap_reg;
            end
            EMIT_PEND:
            begin
                rsp_next.has_record     = 1'b1;
                rsp_next.record_seq     = pend_seq_reg;
                rsp_next.record_payload = 32'(pend_pay_reg);
                rsp_next.gap_before     = cmd.since & gap_reg;
            end
            EMIT_READ:
            begin
                rsp_next.has_record     = 1'b1;
                rsp_next.record_seq     = rd_seq_reg;
                rsp_next.record_payload = 32'(rd_pay_reg);
                rsp_next.gap_before     = cmd.since & gap_reg;
            end
            default:
            begin
                rsp_next.has_record = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            ring_payload[head_reg] <= pay_in;
            ring_seq[head_reg]     <= seq_reg;
        end
        if (cmd.do_read)
        begin
            rd_pay_reg <= ring_payload[rd_ptr_reg];
            rd_seq_reg <= ring_seq[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            cursor_reg <= req.after_seq;
        if (cmd.take_pend)
        begin
            pend_seq_reg <= rd_seq_reg;
            pend_pay_reg <= rd_pay_reg;
        end
        if (cmd.emit != EMIT_NONE)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            held_reg       <= '0;
            seq_reg        <= '0;
            drops_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            rd_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
            gap_reg        <= 1'b0;
            rd_first_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            held_reg       <= held_next;
            seq_reg        <= seq_next;
            drops_reg      <= drops_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_valid_reg <= pend_valid_next;
            gap_reg        <= gap_next;
            rd_first_reg   <= rd_first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign status.out_free   = !out_valid_reg || rsp_ready;
    assign status.walk_done  = (idx_reg == cnt_reg);
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.rd_match   = (rd_seq_reg > cursor_reg);
    assign status.pend_valid = pend_valid_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/sequenced_event_ring_log_unit.sv =====
// sequenced_event_ring_log_unit: top level of the sequenced event ring log
// joins the request sequencer serl_ctrl and the ring datapath serl_dpath
// depends on serl_pkg, serl_ctrl, serl_dpath
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+---------------------
//   request | req_valid, req_ready     | in        | serl_pkg::req_item_t
//   result  | rsp_valid, rsp_ready     | out       | serl_pkg::rsp_item_t
//
// append and clear are taken straight from idle and can follow back to back while results drain
// since and tail walk the ring through one read port, passing S_WALK and S_CHECK for each record
// walked and ending in S_FINISH; a since request walks every held record
// rsp is a single output register; the walk pauses while a result waits to be taken
// reset is asynchronous; ring contents are not cleared, only written entries are read
`timescale 1ns / 1ps
`default_nettype none

module sequenced_event_ring_log_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  serl_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output serl_pkg::rsp_item_t rsp
);
    import serl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    serl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .status    (status),
        .cmd       (cmd)
    );

    serl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sequenced_event_ring_log_unit_test.sv =====
// sequenced_event_ring_log_unit_test: self-checking bench for the sequenced event ring log
// drives random and directed requests, predicts every result and compares field by field
// depends on serl_pkg and sequenced_event_ring_log_unit
`timescale 1ns / 1ps

module sequenced_event_ring_log_unit_test;
    import serl_pkg::*;

    localparam int PHASE_ITEMS = 35;
    localparam int HOLD_CYCLES = 400;
    localparam logic [31:0] PAY_MASK = (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << PAYLOAD_BITS) - 64'd1);

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    sequenced_event_ring_log_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // mirror of the ring log
    logic [31:0] log_payload [DEPTH];
    logic [63:0] log_seq [DEPTH];
    int unsigned log_head     = 0;
    int unsigned log_held     = 0;
    logic [63:0] log_next_seq = '0;
    logic [31:0] log_drops    = '0;

    req_item_t   queued_requests [$];
    rsp_item_t   due_log_results [$];
    logic [63:0] appends_queued = '0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          errors         = 0;
    bit          hold_go        = 1'b0;
    logic        rsp_hold       = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void expect_result(bit has, logic [63:0] seq, logic [31:0] pay,
                                          bit last, bit gap);
        rsp_item_t r;
        r.has_record     = has;
        r.record_seq     = has ? seq : '0;
        r.record_payload = has ? pay : '0;
        r.last           = last;
        r.gap_before     = gap;
        r.held_count     = log_held[6:0];
        r.next_seq       = log_next_seq;
        r.dropped_count  = log_drops;
        due_log_results.insert(due_log_results.size(), r);
    endfunction

    function automatic void predict_log_results(req_item_t q);
        int unsigned first;
        int unsigned slot;
        int unsigned n;
        logic [63:0] oldest;
        bit          gap;
        int unsigned hits [$];
        case (q.req_type)
            REQ_APPEND:
            begin
                slot = log_head;
                if (log_held >= DEPTH && log_drops != 32'hFFFF_FFFF)
                    log_drops = log_drops + 32'd1;
                log_payload[slot] = q.event_payload & PAY_MASK;
                log_seq[slot]     = log_next_seq;
                log_next_seq      = log_next_seq + 64'd1;
                log_head          = (slot + 1) % DEPTH;
                if (log_held < DEPTH)
                    log_held++;
                expect_result(1'b1, log_seq[slot], log_payload[slot], 1'b1, 1'b0);
            end
            REQ_SINCE:
            begin
                first = (log_head + DEPTH - log_held) % DEPTH;
                if (log_held == 0)
                    gap = (log_drops != 0);
                else
                begin
                    oldest = log_seq[first];
                    gap    = (oldest > q.after_seq) && (oldest - q.after_seq > 64'd1);
                end
                for (int i = 0; i < log_held; i++)
                begin
                    slot = (first + i) % DEPTH;
                    if (log_seq[slot] > q.after_seq)
                        hits.insert(hits.size(), slot);
                end
                if (hits.size() == 0)
                    expect_result(1'b0, '0, '0, 1'b1, gap);
                foreach (hits[i])
                    expect_result(1'b1, log_seq[hits[i]], log_payload[hits[i]],
                                  i == hits.size() - 1, gap);
            end
            REQ_TAIL:
            begin
                n     = (q.tail_count < log_held) ? q.tail_count : log_held;
                first = (log_head + DEPTH - n) % DEPTH;
                if (n == 0)
                    expect_result(1'b0, '0, '0, 1'b1, 1'b0);
                for (int i = 0; i < n; i++)
                begin
                    slot = (first + i) % DEPTH;
                    expect_result(1'b1, log_seq[slot], log_payload[slot], i + 1 == n, 1'b0);
                end
            end
            default:
            begin
                // clear keeps the sequence counter
                log_head  = 0;
                log_held  = 0;
                log_drops = '0;
                expect_result(1'b0, '0, '0, 1'b1, 1'b0);
            end
        endcase
    endfunction

    task automatic check_log_result(rsp_item_t got);
        rsp_item_t want;
        if (due_log_results.size() == 0)
        begin
            report_mismatch("unexpected result seq", got.record_seq, '0);
            return;
        end
        want = due_log_results.pop_front();
        if (got.has_record !== want.has_record)
            report_mismatch("has_record", got.has_record, want.has_record);
        if (got.record_seq !== want.record_seq)
            report_mismatch("record_seq", got.record_seq, want.record_seq);
        if (got.record_payload !== want.record_payload)
            report_mismatch("record_payload", got.record_payload, want.record_payload);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        if (got.gap_before !== want.gap_before)
            report_mismatch("gap_before", got.gap_before, want.gap_before);
        if (got.held_count !== want.held_count)
            report_mismatch("held_count", got.held_count, want.held_count);
        if (got.next_seq !== want.next_seq)
            report_mismatch("next_seq", got.next_seq, want.next_seq);
        if (got.dropped_count !== want.dropped_count)
            report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
    endtask

    // request driver: a transaction holds until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                predict_log_results(req);
            if (!req_valid || req_ready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= queued_requests.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                check_log_result(rsp);
            rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    function automatic void queue_request(logic [1:0] kind, logic [31:0] pay,
                                          logic [63:0] cursor, logic [7:0] count);
        req_item_t q;
        q.req_type      = kind;
        q.event_payload = pay;
        q.after_seq     = cursor;
        q.tail_count    = count;
        queued_requests.insert(queued_requests.size(), q);
        if (kind == REQ_APPEND)
            appends_queued = appends_queued + 64'd1;
    endfunction

    function automatic void queue_random_request();
        int          pick;
        int          cur_pick;
        logic [63:0] cursor;
        logic [7:0]  count;
        pick     = $urandom_range(99);
        cur_pick = $urandom_range(9);
        if (cur_pick < 6)
            cursor = appends_queued - 64'($urandom_range(20));
        else if (cur_pick == 6)
            cursor = '0;
        else if (cur_pick == 7)
            cursor = '1;
        else
            cursor = {$urandom, $urandom};
        count = ($urandom_range(99) < 80) ? 8'($urandom_range(20)) : 8'($urandom);
        if (pick < 58)
            queue_request(REQ_APPEND, $urandom, cursor, count);
        else if (pick < 78)
            queue_request(REQ_SINCE, $urandom, cursor, count);
        else if (pick < 97)
            queue_request(REQ_TAIL, $urandom, cursor, count);
        else
            queue_request(REQ_CLEAR, $urandom, cursor, count);
    endfunction

    task automatic wait_drained();
        while (queued_requests.size() != 0 || req_valid || due_log_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty log, extremes, overflow with a gap, clear
        queue_request(REQ_SINCE, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_TAIL, 32'h0, 64'h0, 8'd0);
        queue_request(REQ_TAIL, 32'h0, 64'h0, 8'hFF);
        queue_request(REQ_CLEAR, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_APPEND, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_APPEND, 32'hFFFF_FFFF, '1, 8'hFF);
        queue_request(REQ_SINCE, 32'h0, '1, 8'h0);
        queue_request(REQ_SINCE, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_TAIL, 32'h0, 64'h0, 8'd1);
        queue_request(REQ_TAIL, 32'h0, 64'h0, 8'hFF);
        for (int i = 0; i < 16; i++)
            queue_request(REQ_APPEND, $urandom, 64'h0, 8'h0);
        queue_request(REQ_SINCE, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_CLEAR, 32'h0, 64'h0, 8'h0);
        queue_request(REQ_SINCE, 32'h0, 64'd5, 8'h0);
        wait_drained();

        // full rate with a long receiver hold-off
        for (int i = 0; i < PHASE_ITEMS; i++)
            queue_random_request();
        hold_go = 1'b1;
        wait_drained();

        send_idle_pct  = 86;
        recv_stall_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
            queue_random_request();
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 86;
        for (int i = 0; i < PHASE_ITEMS; i++)
            queue_random_request();
        wait_drained();

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        for (int i = 0; i < PHASE_ITEMS; i++)
            queue_random_request();
        wait_drained();

        // catch any stray result
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
